FILE: rtl/fqs_pkg.sv
// shared types and constants for the searchable fifo queue
package fqs_pkg;

  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = 32 + CW;

  typedef enum logic [2:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_MAX   = 3'd2,
    OP_MIN   = 3'd3,
    OP_LOC   = 3'd4,
    OP_REM   = 3'd5,
    OP_AVG   = 3'd6,
    OP_CLR   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_PUSH,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [31:0]       answer;
    logic [CW-1:0]     count;
    logic [31:0]       front;
    logic [31:0]       back;
  } res_t;

endpackage

FILE: rtl/fqs_ram.sv
// generic single-write, single-read ram with registered read
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/fqs_front.sv
// input stage: two-entry command queue between the stream port and the engine
module fqs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fqs_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output fqs_pkg::cmd_t cmd
);
  import fqs_pkg::*;

  cmd_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |=> cnt_r == 2'd2)
    else $error("command queue lost entry");
  a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("waiting command changed");
endmodule

FILE: rtl/fqs_div.sv
// signed sum divided by count, restoring, one quotient bit per cycle
module fqs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [fqs_pkg::SW-1:0] dividend,
  input  logic [fqs_pkg::CW-1:0]       divisor,
  output logic                         done,
  output logic [31:0]                  quotient
);
  import fqs_pkg::*;

  localparam int NB = $clog2(SW + 1);

  logic [SW-1:0] q_r, q_nxt;
  logic [SW:0]   rem_r, rem_nxt;
  logic [NB-1:0] n_r;
  logic          busy_r, neg_r;
  logic [SW:0]   trial;

  always_comb begin
    trial   = {rem_r[SW-1:0], q_r[SW-1]} - {{(SW+1-CW){1'b0}}, divisor};
    q_nxt   = {q_r[SW-2:0], ~trial[SW]};
    rem_nxt = trial[SW] ? {rem_r[SW-1:0], q_r[SW-1]} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= NB'(SW);
        neg_r  <= dividend[SW-1];
        q_r    <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        n_r   <= n_r - 1'b1;
        if (n_r == NB'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  logic [SW-1:0] qs;
  assign qs       = neg_r ? SW'(-q_r) : q_r;
  assign quotient = qs[31:0];
endmodule

FILE: rtl/fqs_engine.sv
// back end: executes operations on the circular store, one entry per cycle
module fqs_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  fqs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output fqs_pkg::res_t res
);
  import fqs_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cur_r;
  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] k_r, kept_r;
  logic [CW-1:0] rd_k_r;
  logic          rd_v_r;
  logic          ok_r;
  logic [31:0]   ans_r;
  logic signed [SW-1:0] sum_r;
  logic          found_r;
  logic          fetch_ph_r;
  logic [31:0]   front_r;
  logic          res_valid_r;
  res_t          res_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic          div_start, div_done;
  logic [31:0]   quot;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] p;
    p = {1'b0, CW'(h)} + {1'b0, o};
    if (p >= (CW+1)'(DEPTH)) p = p - (CW+1)'(DEPTH);
    return p[AW-1:0];
  endfunction

  fqs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  fqs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r),
    .divisor(cnt_r), .done(div_done), .quotient(quot)
  );

  logic scan_last;
  assign scan_last = (k_r == cnt_r);
  assign cmd_ready = (state_r == ST_IDLE) && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    we        = 1'b0;
    waddr     = tail_r;
    wdata     = cmd.value;
    raddr     = head_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        raddr = head_r;
        if (cmd_valid && cmd_ready) begin
          case (cmd.op)
            OP_ENQ: begin
              we = (cnt_r != CW'(DEPTH));
              state_nxt = ST_FETCH;
            end
            OP_DEQ, OP_CLR: state_nxt = ST_FETCH;
            default: state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        raddr = slot(head_r, k_r);
        if (rd_v_r && cur_r.op == OP_REM && rdata != cur_r.value) begin
          we    = 1'b1;
          waddr = slot(head_r, kept_r);
          wdata = rdata;
        end
        if (scan_last && !rd_v_r) begin
          state_nxt = (cur_r.op == OP_AVG && cnt_r != '0) ? ST_DIV : ST_FETCH;
          div_start = (cur_r.op == OP_AVG && cnt_r != '0);
        end
      end
      ST_DIV: if (div_done) state_nxt = ST_PUSH;
      ST_PUSH: begin
        we        = (cnt_r != CW'(DEPTH));
        wdata     = ans_r;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        raddr = fetch_ph_r ? slot(head_r, cnt_r - 1'b1)
                           : slot(head_r, CW'(cur_r.op == OP_DEQ && cnt_r != '0));
        if (fetch_ph_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        raddr     = head_r;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      fetch_ph_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur_r   <= cmd;
            ok_r    <= 1'b0;
            ans_r   <= '0;
            k_r     <= '0;
            kept_r  <= '0;
            rd_v_r  <= 1'b0;
            sum_r   <= '0;
            found_r <= 1'b0;
            fetch_ph_r <= 1'b0;
            case (cmd.op)
              OP_ENQ: if (cnt_r != CW'(DEPTH)) begin
                tail_r <= slot(tail_r, CW'(1));
                cnt_r  <= cnt_r + 1'b1;
                ok_r   <= 1'b1;
              end
              OP_DEQ: ;
              OP_MIN, OP_LOC: ans_r <= '1;
              OP_CLR: begin
                head_r <= '0;
                tail_r <= '0;
                cnt_r  <= '0;
                ok_r   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          rd_v_r <= !scan_last;
          rd_k_r <= k_r;
          if (!scan_last) k_r <= k_r + 1'b1;
          if (rd_v_r) begin
            case (cur_r.op)
              OP_MAX: if (rd_k_r == '0 || $signed(rdata) > $signed(ans_r)) begin
                ans_r <= rdata;
                ok_r  <= 1'b1;
              end
              OP_MIN: if (rd_k_r == '0 || $signed(rdata) < $signed(ans_r)) begin
                ans_r <= rdata;
                ok_r  <= 1'b1;
              end
              OP_LOC: if (!found_r && rdata == cur_r.value) begin
                found_r <= 1'b1;
                ok_r    <= 1'b1;
                ans_r   <= 32'(rd_k_r) + 32'd1;
              end
              OP_REM: if (rdata == cur_r.value) ok_r <= 1'b1;
                      else kept_r <= kept_r + 1'b1;
              OP_AVG: sum_r <= sum_r + SW'($signed(rdata));
              default: ;
            endcase
          end
          if (scan_last && !rd_v_r && cur_r.op == OP_REM) begin
            cnt_r  <= kept_r;
            tail_r <= slot(head_r, kept_r);
          end
        end
        ST_DIV: if (div_done) ans_r <= quot;
        ST_PUSH: if (cnt_r != CW'(DEPTH)) begin
          tail_r <= slot(tail_r, CW'(1));
          cnt_r  <= cnt_r + 1'b1;
          ok_r   <= 1'b1;
        end
        ST_FETCH: begin
          if (!fetch_ph_r) begin
            if (cur_r.op == OP_DEQ && cnt_r != '0) begin
              ans_r  <= rdata;
              ok_r   <= 1'b1;
              head_r <= slot(head_r, CW'(1));
              cnt_r  <= cnt_r - 1'b1;
            end
            fetch_ph_r <= 1'b1;
          end
        end
        ST_DONE: begin
          res_valid_r  <= 1'b1;
          res_r.ok     <= ok_r;
          res_r.answer <= ans_r;
          res_r.count  <= cnt_r;
          res_r.front  <= (cnt_r == '0) ? '0 : front_r;
          res_r.back   <= (cnt_r == '0) ? '0 : rdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FETCH && fetch_ph_r) front_r <= rdata;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("occupancy above depth");
  a_idx_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> slot(head_r, cnt_r) == tail_r)
    else $error("head, tail and count disagree");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_ready |=> res_valid_r && $stable(res_r))
    else $error("result dropped while stalled");
endmodule

FILE: rtl/fifo_queue_with_search.sv
// top level of the fifo queue with search operations
//  channel | dir | tdata fields (low to high)             | tuser
//  in_     | in  | operation[2:0], operand_value[34:3]    | -
//  out_    | out | answer[31:0], entry_count[38:32],      | ok
//          |     | front_value[70:39], back_value[102:71] |
// enqueue, dequeue, clear: fetch and done states; max, min, locate, remove scan the
// occupancy first, one store read per cycle on the single read port;
// average adds the bit-serial divide and the append. rst_n is
// synchronous; a two-entry command queue accepts commands until full while the engine or output stalls.
module fifo_queue_with_search (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // operation, operand_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // answer, entry_count, front_value, back_value
  output logic         out_tuser   // ok
);
  import fqs_pkg::*;

  cmd_t in_cmd, cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  assign in_cmd.op    = op_t'(in_tdata[2:0]);
  assign in_cmd.value = in_tdata[34:3];

  fqs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  fqs_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tuser = res.ok;
  assign out_tdata = {1'b0, res.back, res.front, 7'(res.count), res.answer};
endmodule
